@@ sv/multichannel_biquad_filter_assert.svh @@
// Assertion macros for the biquad filter block.
`ifndef MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define MBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MBF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MBF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/mbf_pkg.sv @@
package mbf_pkg;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_BITS      = 24;
    localparam int CHAN_BITS      = 3;
    localparam int NUM_REGS       = 5;
    localparam int REG_IDX_BITS   = 3;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;

    typedef logic        [CHAN_BITS-1:0]   t_chan;
    typedef logic        [CH_W-1:0]        t_idx;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } t_reg_idx;

    // per-channel history word
    typedef struct packed {
        t_sample in_one;
        t_sample in_two;
        t_sample out_one;
        t_sample out_two;
    } t_hist;

    localparam t_coef COEF_ONE = t_coef'(64'sd1 <<< COEF_FRAC_BITS);
    localparam t_acc  ACC_RND  = t_acc'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam t_acc  ACC_HI   = t_acc'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam t_acc  ACC_LO   = t_acc'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

endpackage

@@ sv/multichannel_biquad_filter.sv @@
// Multichannel biquad filter, direct form I, fixed point.
// Input stream: tuser = channel number, tdata = signed sample. Output stream:
// tuser = channel, tdata = filtered sample, rounded half up and saturated.
// Coefficients b0, b1, b2, a1, a2 (signed Q3.20) are written through the cfg
// port at indexes 0..4; other indexes are ignored. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Per-channel history (x1, x2, y1, y2) lives in one synchronous RAM word per
// channel; each entry reads as zero until its channel has been written once.
// Pipeline: RAM read at accept into stage 1, five products into stage 2, sum,
// round, saturate and write-back as the result enters the output register.
// Throughput: one sample per cycle while consecutive samples alternate
// channels and the output is not stalled; a repeated channel waits while its
// last sample is in stage 1 (history read-modify-write, write-back forwarded).
// Reset clears the pipeline, history valid flags and coefficients (b0 = 1.0).
// A stalled output stalls the pipeline; the input keeps accepting until the
// stages in front of the output register are full.
module multichannel_biquad_filter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  mbf_pkg::t_chan          i_s_axis_tuser,  // [2:0] chan
    input  mbf_pkg::t_sample        i_s_axis_tdata,  // [23:0] sample_in
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output mbf_pkg::t_chan          o_m_axis_tuser,  // [2:0] chan_out
    output mbf_pkg::t_sample        o_m_axis_tdata,  // [23:0] sample_out
    input  logic                    i_cfg_wen,
    input  logic [mbf_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  mbf_pkg::t_coef          i_cfg_wdata
);
    import mbf_pkg::*;

    t_coef   r_coef [NUM_REGS];
    t_hist   r_mem  [CHANNELS];
    logic [CHANNELS-1:0] r_vld;

    // stage 1: RAM data available
    logic    r_s1_vld, r_s1_in, r_s1_hv, r_s1_fwd;
    t_chan   r_s1_ch;
    t_sample r_s1_x;
    t_hist   r_rd, r_s1_fdat;

    // stage 2: products
    logic    r_s2_vld, r_s2_in;
    t_chan   r_s2_ch;
    t_sample r_s2_x, r_s2_x1, r_s2_y1;
    t_prod   r_p [5];

    // output register
    logic    r_ovld;
    t_chan   r_och;
    t_sample r_oy;

    logic    out_free, s2_go, s2_free, s1_go, s1_free, hazard, acc;
    logic    in_rng, fwd;
    t_hist   h;
    t_prod   n_p [5];
    t_acc    sum, shf;
    t_sample y;
    t_hist   n_wdat;

    assign out_free = !r_ovld || i_m_axis_tready;
    assign s2_go    = r_s2_vld && out_free;
    assign s2_free  = !r_s2_vld || s2_go;
    assign s1_go    = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s1_go;

    assign in_rng = (32'(i_s_axis_tuser) < CHANNELS);
    assign hazard = (r_s1_vld && r_s1_in && r_s1_ch == i_s_axis_tuser)
                 || (r_s2_vld && !s2_go && r_s2_in && r_s2_ch == i_s_axis_tuser);
    assign fwd    = s2_go && r_s2_in && r_s2_ch == i_s_axis_tuser;

    assign o_s_axis_tready = s1_free && !hazard;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_s1_fwd) begin
            h = r_s1_fdat;
        end else if (r_s1_hv) begin
            h = r_rd;
        end else begin
            h = '0;
        end
        n_p[0] = r_coef[REG_B0] * r_s1_x;
        n_p[1] = r_coef[REG_B1] * h.in_one;
        n_p[2] = r_coef[REG_B2] * h.in_two;
        n_p[3] = r_coef[REG_A1] * h.out_one;
        n_p[4] = r_coef[REG_A2] * h.out_two;
    end

    always_comb begin
        sum = t_acc'(r_p[0]) + t_acc'(r_p[1]) + t_acc'(r_p[2])
            - t_acc'(r_p[3]) - t_acc'(r_p[4]) + ACC_RND;
        shf = sum >>> COEF_FRAC_BITS;
        if (shf > ACC_HI) begin
            y = t_sample'(ACC_HI);
        end else if (shf < ACC_LO) begin
            y = t_sample'(ACC_LO);
        end else begin
            y = shf[SAMPLE_BITS-1:0];
        end
        n_wdat.in_one  = r_s2_x;
        n_wdat.in_two  = r_s2_x1;
        n_wdat.out_one = y;
        n_wdat.out_two = r_s2_y1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_vld    <= '0;
            r_coef[REG_B0] <= COEF_ONE;
            r_coef[REG_B1] <= '0;
            r_coef[REG_B2] <= '0;
            r_coef[REG_A1] <= '0;
            r_coef[REG_A2] <= '0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= acc;
                r_s1_fwd <= acc && fwd;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_ovld <= r_s2_vld;
            end
            if (s2_go && r_s2_in) begin
                r_vld[t_idx'(r_s2_ch)] <= 1'b1;
            end
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    REG_B0:  r_coef[REG_B0] <= i_cfg_wdata;
                    REG_B1:  r_coef[REG_B1] <= i_cfg_wdata;
                    REG_B2:  r_coef[REG_B2] <= i_cfg_wdata;
                    REG_A1:  r_coef[REG_A1] <= i_cfg_wdata;
                    REG_A2:  r_coef[REG_A2] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // history RAM, registered read
    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_in) begin
            r_mem[t_idx'(r_s2_ch)] <= n_wdat;
        end
        if (acc) begin
            r_rd <= r_mem[t_idx'(i_s_axis_tuser)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ch   <= i_s_axis_tuser;
            r_s1_x    <= i_s_axis_tdata;
            r_s1_in   <= in_rng;
            r_s1_hv   <= r_vld[t_idx'(i_s_axis_tuser)];
            r_s1_fdat <= n_wdat;
        end
        if (s1_go) begin
            r_s2_ch  <= r_s1_ch;
            r_s2_in  <= r_s1_in;
            r_s2_x   <= r_s1_x;
            r_s2_x1  <= h.in_one;
            r_s2_y1  <= h.out_one;
            r_p      <= n_p;
        end
        if (s2_go) begin
            r_och <= r_s2_ch;
            r_oy  <= r_s2_in ? y : '0;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tuser  = r_och;
    assign o_m_axis_tdata  = r_oy;

    `include "multichannel_biquad_filter_assert.svh"

    `MBF_ASSERT_NEVER(a_no_same_ch_inflight, i_clk, i_rst_n, r_s1_vld && r_s2_vld && r_s1_in && r_s2_in && r_s1_ch == r_s2_ch, "same channel in two stages")
    `MBF_ASSERT(a_fwd_follows_write, i_clk, i_rst_n, r_s1_fwd && $past(s1_free) |-> $past(s2_go && r_s2_in), "forward without write-back")
    `MBF_ASSERT(a_vld_monotonic, i_clk, i_rst_n, $countones(r_vld) >= $past($countones(r_vld)), "history valid flag lost")
    `MBF_ASSERT(a_s2_hold, i_clk, i_rst_n, (r_s2_vld && !s2_go) |=> r_s2_vld, "stage 2 dropped while stalled")

endmodule

@@ sim/multichannel_biquad_filter_test.sv @@
module multichannel_biquad_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam t_sample SAMPLE_MAX = t_sample'(24'h7FFFFF);
    localparam t_sample SAMPLE_MIN = t_sample'(24'h800000);
    localparam t_coef   COEF_MAX   = t_coef'(24'h7FFFFF);
    localparam t_coef   COEF_MIN   = t_coef'(24'h800000);
    localparam t_coef   COEF_HALF  = t_coef'(24'h080000);

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } t_rx_mode;
    typedef enum int { WALK_RANDOM, WALK_REPEAT, WALK_SWEEP } t_chan_walk;

    typedef struct {
        t_chan   chan;
        t_sample sample;
    } t_filtered;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    t_chan                   i_s_axis_tuser;  // [2:0] chan
    t_sample                 i_s_axis_tdata;  // [23:0] sample_in
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    t_chan                   o_m_axis_tuser;  // [2:0] chan_out
    t_sample                 o_m_axis_tdata;  // [23:0] sample_out
    logic                    i_cfg_wen;
    logic [REG_IDX_BITS-1:0] i_cfg_idx;
    t_coef                   i_cfg_wdata;

    t_coef     coef_q  [NUM_REGS];
    t_sample   hist_x1 [CHANNELS];
    t_sample   hist_x2 [CHANNELS];
    t_sample   hist_y1 [CHANNELS];
    t_sample   hist_y2 [CHANNELS];
    t_filtered pending_outputs[$];

    int       errors      = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       gap_max     = 0;
    int       rx_hold     = 0;
    int       rx_tick     = 0;
    t_rx_mode rx_mode     = RX_ALWAYS;
    logic [7:0] rx_pattern = 8'hFF;

    multichannel_biquad_filter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multichannel_biquad_filter_test: errors");
            $finish;
        end
    end

    // y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, round half up, saturate
    function automatic t_sample filter_step(t_chan ch, t_sample x);
        longint acc;
        longint y;
        longint smax;
        longint smin;
        smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        smin = -smax - 1;
        acc = longint'(coef_q[REG_B0]) * longint'(x)
            + longint'(coef_q[REG_B1]) * longint'(hist_x1[ch])
            + longint'(coef_q[REG_B2]) * longint'(hist_x2[ch])
            - longint'(coef_q[REG_A1]) * longint'(hist_y1[ch])
            - longint'(coef_q[REG_A2]) * longint'(hist_y2[ch]);
        acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;
        if (y > smax) y = smax;
        if (y < smin) y = smin;
        hist_x2[ch] = hist_x1[ch];
        hist_x1[ch] = x;
        hist_y2[ch] = hist_y1[ch];
        hist_y1[ch] = t_sample'(y);
        return t_sample'(y);
    endfunction

    // receiver: long hold-off first, then the phase's stall pattern
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_axis_tready = 1'b1;
                RX_RANDOM:  i_m_axis_tready = ($urandom_range(0, 3) != 0);
                RX_PATTERN: i_m_axis_tready = rx_pattern[rx_tick % 8];
                default:    i_m_axis_tready = 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_filtered exp_out;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                errors++;
                $error("unexpected transaction: chan_out %0d sample_out %0d",
                       o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                exp_out = pending_outputs.pop_front();
                if (o_m_axis_tuser !== exp_out.chan) begin
                    errors++;
                    $error("chan_out mismatch: expected %0d, actual %0d",
                           exp_out.chan, o_m_axis_tuser);
                end
                if (o_m_axis_tdata !== exp_out.sample) begin
                    errors++;
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           exp_out.sample, o_m_axis_tdata);
                end
            end
        end
    end

    // called right after a falling edge; returns right after a falling edge
    task automatic send_sample(input t_chan ch, input t_sample x);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = ch;
        i_s_axis_tdata  = x;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_outputs.push_back('{chan: ch, sample: filter_step(ch, x)});
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_coef(input logic [REG_IDX_BITS-1:0] idx, input t_coef value);
        i_cfg_wen   = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        if (idx < NUM_REGS) coef_q[idx] = value;
    endtask

    task automatic write_all_coefs(input t_coef b0, input t_coef b1, input t_coef b2,
                                   input t_coef a1, input t_coef a2);
        wait_drain();
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
    endtask

    function automatic t_sample rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return t_sample'(int'($urandom_range(0, 512)) - 256);
            3:       return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic test_passthrough();
        t_sample values [CHANNELS];
        values = '{'0, SAMPLE_MAX, SAMPLE_MIN, t_sample'(-1), t_sample'(1),
                   t_sample'(24'h555555), t_sample'(24'hAAAAAA), t_sample'(24'h123456)};
        for (int ch = 0; ch < CHANNELS; ch++) send_sample(t_chan'(ch), values[ch]);
        wait_drain();
    endtask

    task automatic test_unused_index();
        wait_drain();
        for (int k = NUM_REGS; k < 2 ** REG_IDX_BITS; k++) begin
            write_coef(REG_IDX_BITS'(k), t_coef'($urandom));
        end
        send_sample(t_chan'(3), t_sample'(24'h3C3C3C));
        send_sample(t_chan'(3), SAMPLE_MIN);
        wait_drain();
    endtask

    task automatic test_rounding();
        write_all_coefs(COEF_HALF, '0, '0, '0, '0);
        send_sample(t_chan'(0), t_sample'(1));
        send_sample(t_chan'(1), t_sample'(-1));
        send_sample(t_chan'(2), t_sample'(3));
        send_sample(t_chan'(4), t_sample'(-3));
        wait_drain();
    endtask

    task automatic test_saturation();
        write_all_coefs(COEF_MAX, '0, '0, '0, '0);
        send_sample(t_chan'(6), SAMPLE_MAX);
        send_sample(t_chan'(7), SAMPLE_MIN);
        send_sample(t_chan'(6), t_sample'(1));
        wait_drain();
    endtask

    task automatic test_feedback_extremes();
        write_all_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        send_sample(t_chan'(5), SAMPLE_MAX);
        send_sample(t_chan'(5), SAMPLE_MIN);
        send_sample(t_chan'(5), t_sample'(1));
        send_sample(t_chan'(5), '0);
        wait_drain();
    endtask

    task automatic run_random_phase(input int items);
        int         sent;
        int         run_len;
        t_chan_walk walk;
        t_chan      ch;
        sent = 0;
        ch   = t_chan'($urandom);
        while (sent < items) begin
            walk    = t_chan_walk'($urandom_range(0, 2));
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len && sent < items; k++) begin
                case (walk)
                    WALK_RANDOM: ch = t_chan'($urandom);
                    WALK_SWEEP:  ch = ch + 1'b1;
                    default:     ;
                endcase
                send_sample(ch, rand_sample());
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        t_coef c [NUM_REGS];
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: foreach (c[i]) c[i] = t_coef'($urandom);
                1: c = '{t_coef'(5243), t_coef'(10486), t_coef'(5243),
                         t_coef'(-1887437), t_coef'(859832)};
                2: foreach (c[i]) c[i] = t_coef'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
                3: c = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
                4: c = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
                default: begin
                    foreach (c[i]) c[i] = t_coef'(int'($urandom_range(0, 2 ** 20)) - 2 ** 19);
                end
            endcase
            write_all_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);
            if ($urandom_range(0, 1)) begin
                write_coef(REG_IDX_BITS'($urandom_range(NUM_REGS, 2 ** REG_IDX_BITS - 1)),
                           t_coef'($urandom));
            end
            if (p == 0) begin
                gap_max = 0;
                rx_mode = RX_ALWAYS;
            end else begin
                gap_max    = $urandom_range(0, 8);
                rx_mode    = t_rx_mode'($urandom_range(0, 2));
                rx_pattern = 8'($urandom) | 8'h01;
            end
            run_random_phase(150);
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_all_coefs(t_coef'(24'h0C0000), t_coef'(24'hF80000), t_coef'(24'h020000),
                        t_coef'(24'hF40000), t_coef'(24'h060000));
        gap_max = 0;
        rx_mode = RX_RANDOM;
        rx_hold = 80;
        for (int k = 0; k < 30; k++) send_sample(t_chan'($urandom), rand_sample());
        wait_drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = '0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        i_cfg_wen       = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        coef_q          = '{COEF_ONE, '0, '0, '0, '0};
        foreach (hist_x1[i]) begin
            hist_x1[i] = '0;
            hist_x2[i] = '0;
            hist_y1[i] = '0;
            hist_y2[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_unused_index();
        test_rounding();
        test_saturation();
        test_feedback_extremes();
        test_random_phases();
        test_backpressure();

        wait_drain();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("multichannel_biquad_filter_test: clean");
        end else begin
            $display("multichannel_biquad_filter_test: errors");
        end
        $finish;
    end
endmodule
